// ----- rtl/nrd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nrd_pkg;

   // payload store geometry: entry 0 holds the direction byte
   localparam int STORE_DEPTH   = 64;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int LIMIT_W       = 6;
   localparam int LIMIT_RESET   = 63;
   localparam int BUFFER_BYTES_DEFAULT = 64;

   // frame overhead: three header bytes, length, length checksum, data checksum
   localparam int FRAME_OVERHEAD = 6;

   localparam logic [7:0] HDR_ZERO = 8'h00;
   localparam logic [7:0] HDR_LAST = 8'hFF;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_HEADER = 3'd1,
      ST_LCS    = 3'd2,
      ST_SHORT  = 3'd3,
      ST_DCS    = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_data;
      logic [2:0] frame_status;
      logic       last;
   } rsp_type;

   // verdict handed from the parser to the emitter
   typedef struct packed {
      logic               valid;
      logic               replay;
      logic [LIMIT_W-1:0] count;
      status_type         status;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/nrd_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nrd_store (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [nrd_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]                wr_data,
   input  wire logic                      rd_en,
   input  wire logic [nrd_pkg::ADDR_W-1:0] rd_addr,
   output      logic [7:0]                rd_data
);

   logic [7:0] mem_ff [nrd_pkg::STORE_DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/nrd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nrd_parser #(
   parameter int BUFFER_BYTES = nrd_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_fire,
   input  wire nrd_pkg::req_type           req_data,
   input  wire logic                       csr_fire,
   input  wire logic [nrd_pkg::LIMIT_W-1:0] csr_limit,
   output      logic                       wr_en,
   output      logic [nrd_pkg::ADDR_W-1:0]  wr_addr,
   output      logic [7:0]                 wr_data,
   output      nrd_pkg::cmd_type           cmd
);

   localparam int POS_W = $clog2(BUFFER_BYTES - nrd_pkg::FRAME_OVERHEAD + 1);
   localparam logic [8:0] MAX_BYTES = 9'(BUFFER_BYTES);

   typedef enum logic [7:0] {
      PH_H0   = 8'b0000_0001,
      PH_H1   = 8'b0000_0010,
      PH_H2   = 8'b0000_0100,
      PH_LEN  = 8'b0000_1000,
      PH_LCS  = 8'b0001_0000,
      PH_BODY = 8'b0010_0000,
      PH_DCS  = 8'b0100_0000,
      PH_SKIP = 8'b1000_0000
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [7:0]               len_ff, len_in;
   logic [7:0]               sum_ff, sum_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [nrd_pkg::LIMIT_W-1:0] limit_ff;

   logic [7:0]               rx;
   logic                     rx_end;
   logic [7:0]               lcs_sum;
   logic [7:0]               dcs_sum;
   logic [7:0]               body_sum;
   logic [7:0]               payload_len;
   logic [nrd_pkg::LIMIT_W-1:0] count;
   logic                     too_long;
   logic                     body_done;
   logic                     verdict;
   nrd_pkg::status_type      vstat;

   assign rx       = req_data.rx_byte;
   assign rx_end   = req_data.buffer_end;
   assign lcs_sum  = len_ff + rx;
   assign dcs_sum  = sum_ff + rx;
   assign body_sum = sum_ff + rx;
   assign too_long = (9'(len_ff) + 9'(nrd_pkg::FRAME_OVERHEAD)) > MAX_BYTES;
   assign body_done = (9'(pos_ff) + 9'd1) >= 9'(len_ff);

   // payload bytes delivered, capped by the limit register
   assign payload_len = len_ff - 8'd1;
   assign count = (payload_len > 8'(limit_ff)) ? limit_ff : payload_len[nrd_pkg::LIMIT_W-1:0];

   // body bytes go to the store while they fit
   assign wr_addr = nrd_pkg::ADDR_W'(pos_ff);
   assign wr_data = rx;

   // frame sequencing
   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      pos_in   = pos_ff;
      verdict  = 1'b0;
      vstat    = nrd_pkg::ST_OK;
      wr_en    = 1'b0;
      cmd      = '0;
      if (req_fire) begin
         unique case (phase_ff)
            PH_H0: begin
               if (rx != nrd_pkg::HDR_ZERO) begin
                  verdict = 1'b1;
                  vstat   = nrd_pkg::ST_HEADER;
               end else begin
                  phase_in = PH_H1;
               end
            end
            PH_H1: begin
               if (rx != nrd_pkg::HDR_ZERO) begin
                  verdict = 1'b1;
                  vstat   = nrd_pkg::ST_HEADER;
               end else begin
                  phase_in = PH_H2;
               end
            end
            PH_H2: begin
               if (rx != nrd_pkg::HDR_LAST) begin
                  verdict = 1'b1;
                  vstat   = nrd_pkg::ST_HEADER;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               len_in   = rx;
               phase_in = PH_LCS;
            end
            PH_LCS: begin
               if (lcs_sum != 8'd0) begin
                  verdict = 1'b1;
                  vstat   = nrd_pkg::ST_LCS;
               end else if (len_ff == 8'd0 || too_long) begin
                  verdict = 1'b1;
                  vstat   = nrd_pkg::ST_SHORT;
               end else begin
                  sum_in   = 8'd0;
                  pos_in   = '0;
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               sum_in = body_sum;
               wr_en  = 9'(pos_ff) < 9'(nrd_pkg::STORE_DEPTH);
               pos_in = pos_ff + POS_W'(1);
               if (body_done) begin
                  phase_in = PH_DCS;
               end
            end
            PH_DCS: begin
               verdict = 1'b1;
               vstat   = (dcs_sum != 8'd0) ? nrd_pkg::ST_DCS : nrd_pkg::ST_OK;
            end
            PH_SKIP: begin
            end
            default: begin
               phase_in = PH_H0;
            end
         endcase

         // verdict, or an early buffer end
         if (verdict) begin
            cmd.valid  = 1'b1;
            cmd.status = vstat;
            cmd.count  = count;
            cmd.replay = (vstat == nrd_pkg::ST_OK) && (count != '0);
            phase_in   = rx_end ? PH_H0 : PH_SKIP;
         end else if (rx_end) begin
            if (phase_ff != PH_SKIP) begin
               cmd.valid  = 1'b1;
               cmd.status = nrd_pkg::ST_SHORT;
            end
            phase_in = PH_H0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_H0;
         len_ff   <= 8'd0;
         sum_ff   <= 8'd0;
         pos_ff   <= '0;
         limit_ff <= nrd_pkg::LIMIT_W'(nrd_pkg::LIMIT_RESET);
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         pos_ff   <= pos_in;
         if (csr_fire) begin
            limit_ff <= csr_limit;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/nrd_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nrd_emit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire nrd_pkg::cmd_type           cmd,
   output      logic                       idle,
   output      logic                       rd_en,
   output      logic [nrd_pkg::ADDR_W-1:0]  rd_addr,
   input  wire logic [7:0]                 rd_data,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      nrd_pkg::rsp_type           rsp_data
);

   logic                        out_valid_ff;
   nrd_pkg::rsp_type            out_data_ff;
   logic [nrd_pkg::LIMIT_W-1:0] left_ff;
   logic [nrd_pkg::ADDR_W-1:0]  addr_ff;
   logic                        rd_pend_ff;
   logic                        rd_last_ff;
   logic                        out_free;

   // output register is free next cycle when empty or taken now
   assign out_free = !out_valid_ff || !rsp_stall;
   assign idle     = (left_ff == '0) && !rd_pend_ff && out_free;

   // one read in flight; its data passes the store's read register, then lands in the output register
   assign rd_en   = (left_ff != '0) && !rd_pend_ff && out_free;
   assign rd_addr = addr_ff;

   // replay sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         addr_ff    <= '0;
         rd_pend_ff <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         rd_pend_ff <= rd_en;
         if (cmd.valid && cmd.replay) begin
            left_ff <= cmd.count;
            addr_ff <= nrd_pkg::ADDR_W'(1);
         end else if (rd_en) begin
            left_ff    <= left_ff - nrd_pkg::LIMIT_W'(1);
            addr_ff    <= addr_ff + nrd_pkg::ADDR_W'(1);
            rd_last_ff <= (left_ff == nrd_pkg::LIMIT_W'(1));
         end
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rd_pend_ff || (cmd.valid && !cmd.replay)) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         out_data_ff.data_byte    <= rd_data;
         out_data_ff.has_data     <= 1'b1;
         out_data_ff.frame_status <= nrd_pkg::ST_OK;
         out_data_ff.last         <= rd_last_ff;
      end else if (cmd.valid && !cmd.replay) begin
         out_data_ff.data_byte    <= 8'd0;
         out_data_ff.has_data     <= 1'b0;
         out_data_ff.frame_status <= cmd.status;
         out_data_ff.last         <= 1'b1;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTH
   // a verdict never arrives while a replay is still running
   a_cmd_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.valid |-> (left_ff == '0) && !rd_pend_ff)
      else $error("verdict during replay");

   // read data always finds the output register free
   a_land_free: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !(out_valid_ff && rsp_stall))
      else $error("read data lands on a held beat");

   // every read issued shows up as a data beat, via the store's read register and then the output register
   a_read_beat: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> ##2 (out_valid_ff && out_data_ff.has_data))
      else $error("read did not produce a data beat");

   // the last replayed beat ends the replay
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rd_en && left_ff == nrd_pkg::LIMIT_W'(1)) |=> (left_ff == '0))
      else $error("replay count out of step");
`endif

endmodule

`default_nettype wire

// ----- rtl/nfc_response_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Response deframer: takes a received reader buffer one byte per beat (buffer_end on the
// last byte), checks the 00 00 FF header, the length byte against its checksum, and the
// data checksum over the direction byte and payload. A good frame gives its payload bytes
// (direction byte dropped, at most csr_data of them, last on the final one, or one empty
// beat with status ok); any failure gives a single status beat. While a frame is
// received, each byte is taken as it arrives unless the input stalls. Body bytes are
// written into a 64-entry payload memory, and on a good checksum the input stalls while
// that memory is replayed: payload bytes are read one at a time, each passing a memory
// read and then the output register before the next read. The input also stalls while
// a result beat waits on rsp_stall. No clearing pass is needed after reset.
module nfc_response_deframer #(
   parameter int BUFFER_BYTES = nrd_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire nrd_pkg::req_type           req_data,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      nrd_pkg::rsp_type           rsp_data,
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic [nrd_pkg::LIMIT_W-1:0] csr_data
);

   logic                       req_fire;
   logic                       csr_fire;
   logic                       emit_idle;
   logic                       wr_en;
   logic [nrd_pkg::ADDR_W-1:0]  wr_addr;
   logic [7:0]                 wr_data;
   logic                       rd_en;
   logic [nrd_pkg::ADDR_W-1:0]  rd_addr;
   logic [7:0]                 rd_data;
   nrd_pkg::cmd_type           cmd;

   // handshakes
   assign req_stall = !emit_idle;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   nrd_parser #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_data  (req_data),
      .csr_fire  (csr_fire),
      .csr_limit (csr_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .cmd       (cmd)
   );

   nrd_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nrd_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .idle      (emit_idle),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
